### rtl/crrf_pkg.sv
package crrf_pkg;

  // Domains and bytes per register file.
  localparam int DOMAINS     = 2;
  localparam int BLOCK_BYTES = 4096;

  localparam int WORDS_PER_FILE = BLOCK_BYTES / 4;
  localparam int TOTAL_WORDS    = DOMAINS * 2 * WORDS_PER_FILE;
  localparam int WORD_AW        = $clog2(WORDS_PER_FILE);
  localparam int MEM_AW         = $clog2(TOTAL_WORDS);

  // Fixed field widths.
  localparam int OP_W   = 2;
  localparam int OFF_W  = 12;
  localparam int SIZE_W = 3;
  localparam int DATA_W = 32;
  localparam int BIT_W  = 5;
  localparam int LIM_W  = 18;
  localparam int DOM_CW = 4;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Control word window and its set, clear and toggle aliases.
  localparam logic [OFF_W-1:0] CTRL_FIRST = 12'h010;
  localparam logic [OFF_W-1:0] CTRL_LAST  = 12'h018;
  localparam logic [OFF_W-1:0] ALIAS_SET  = 12'h040;
  localparam logic [OFF_W-1:0] ALIAS_CLR  = 12'h070;
  localparam logic [OFF_W-1:0] ALIAS_TOG  = 12'h0A0;
  localparam logic [OFF_W-1:0] ALIAS_SPAN = CTRL_LAST - CTRL_FIRST;

  // Byte lanes covered by an access of the given size.
  function automatic logic [3:0] size_lanes(input logic [SIZE_W-1:0] size);
    logic [3:0] lanes;
    for (int i = 0; i < 4; i++) begin
      lanes[i] = (SIZE_W'(i) < size);
    end
    return lanes;
  endfunction

  // Word index into the combined memory: domain, then file, then word.
  function automatic logic [MEM_AW-1:0] file_index(input logic dom, input logic blk,
                                                   input logic [OFF_W-3:0] word);
    return (MEM_AW'({dom, blk}) << WORD_AW) | MEM_AW'(word);
  endfunction

endpackage

### rtl/clock_reset_control_regfile.sv
// Clock-gate and reset register files for two domains, kept in one single-port-write,
// single-port-read memory with a registered read. After reset the block runs a clearing
// pass over all 4096 words (one word a cycle: clock words to zero, reset words to all ones)
// and holds in_stall high until it is done. A write within one word or a rejected access
// then ends in S_IDLE; a write that spans two words writes its second word in S_WR1; a read
// passes through S_RD0, and S_RD1 too when it spans two words; a set/clear/toggle alias write
// reads the word and writes it back in S_ALIAS; a peripheral query passes through S_Q0 and S_Q1.
// These steps come from the one memory read and one memory write per cycle: reads and alias
// updates wait for the registered read data, and a query reads both the clock and the reset
// word. A finished result waits until the output register is free; in_stall stays high meanwhile.
module clock_reset_control_regfile (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [crrf_pkg::OP_W-1:0]      in_op,
  input  logic                           in_block_select,
  input  logic                           in_domain,
  input  logic [crrf_pkg::OFF_W-1:0]     in_byte_offset,
  input  logic [crrf_pkg::SIZE_W-1:0]    in_access_size,
  input  logic [crrf_pkg::DATA_W-1:0]    in_write_data,
  input  logic [crrf_pkg::BIT_W-1:0]     in_bit_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [crrf_pkg::DATA_W-1:0]    out_read_data,
  output logic                           out_ok,
  output logic                           out_peripheral_active
);
  import crrf_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD0, S_RD1, S_ALIAS, S_WR1, S_Q0, S_Q1
  } state_t;

  typedef enum logic [1:0] {AL_SET, AL_CLR, AL_TOG} alias_t;

  state_t               state_r;
  logic [MEM_AW-1:0]    clr_cnt_r;
  logic [MEM_AW-1:0]    idx0_r, idx1_r;
  logic                 span_r;
  logic [1:0]           lo_r;
  logic [SIZE_W-1:0]    size_r;
  logic [3:0]           be1_r;
  logic [DATA_W-1:0]    data1_r;
  alias_t               alias_r;
  logic [DATA_W-1:0]    w0_r;
  logic [BIT_W-1:0]     bit_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_read_data_r;
  logic                 out_ok_r;
  logic                 out_act_r;
  logic [DATA_W-1:0]    res_rd_r;
  logic                 res_ok_r, res_act_r;
  logic                 pending_r;

  // Memory.
  logic [DATA_W-1:0]    mem [TOTAL_WORDS];
  logic [DATA_W-1:0]    rd_data_r;
  logic                 rd_en, wr_en;
  logic [MEM_AW-1:0]    rd_addr, wr_addr;
  logic [3:0]           wr_be;
  logic [DATA_W-1:0]    wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < 4; b++) begin
        if (wr_be[b]) begin
          mem[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
        end
      end
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Input decode.
  logic                 accept;
  logic [1:0]           lo;
  logic                 size_ok, range_ok, dom_ok, rw_ok, span, qry_ok;
  logic [7:0]           be64;
  logic [2*DATA_W-1:0]  wdata64;
  logic [OFF_W-3:0]     word0, word1;
  logic                 hit_set, hit_clr, hit_tog, is_alias;
  logic [OFF_W-1:0]     win_base, alias_off;
  alias_t               alias_kind;

  assign accept   = in_valid && !in_stall;
  assign lo       = in_byte_offset[1:0];
  assign size_ok  = (in_access_size != '0) && (in_access_size <= SIZE_W'(4));
  assign range_ok = (LIM_W'(in_byte_offset) + LIM_W'(in_access_size)) <= LIM_W'(BLOCK_BYTES);
  assign dom_ok   = DOM_CW'(in_domain) < DOM_CW'(DOMAINS);
  assign rw_ok    = size_ok && range_ok && dom_ok;
  assign span     = (3'(lo) + in_access_size) > 3'd4;
  assign qry_ok   = dom_ok && (in_byte_offset >= CTRL_FIRST) && (in_byte_offset <= CTRL_LAST);
  assign be64     = 8'(size_lanes(in_access_size)) << lo;
  assign wdata64  = (2*DATA_W)'(in_write_data) << {lo, 3'b000};
  assign word0    = in_byte_offset[OFF_W-1:2];
  assign word1    = word0 + 1'b1;

  assign hit_set  = (in_byte_offset >= ALIAS_SET) && (in_byte_offset <= ALIAS_SET + ALIAS_SPAN);
  assign hit_clr  = (in_byte_offset >= ALIAS_CLR) && (in_byte_offset <= ALIAS_CLR + ALIAS_SPAN);
  assign hit_tog  = (in_byte_offset >= ALIAS_TOG) && (in_byte_offset <= ALIAS_TOG + ALIAS_SPAN);
  assign is_alias = (in_access_size == SIZE_W'(4)) && (hit_set || hit_clr || hit_tog);

  always_comb begin
    if (hit_set) begin
      win_base   = ALIAS_SET;
      alias_kind = AL_SET;
    end else if (hit_clr) begin
      win_base   = ALIAS_CLR;
      alias_kind = AL_CLR;
    end else begin
      win_base   = ALIAS_TOG;
      alias_kind = AL_TOG;
    end
  end
  assign alias_off = in_byte_offset - win_base + CTRL_FIRST;

  // Read data assembly and alias update.
  logic [2*DATA_W-1:0]  rd_pair, rd_shift;
  logic [DATA_W-1:0]    rd_mask, read_val, alias_val;
  logic [3:0]           rd_lanes;

  assign rd_pair  = (state_r == S_RD1) ? {rd_data_r, w0_r} : {{DATA_W{1'b0}}, rd_data_r};
  assign rd_shift = rd_pair >> {lo_r, 3'b000};
  assign rd_lanes = size_lanes(size_r);
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      rd_mask[8*b +: 8] = {8{rd_lanes[b]}};
    end
  end
  assign read_val = rd_shift[DATA_W-1:0] & rd_mask;

  always_comb begin
    case (alias_r)
      AL_SET:  alias_val = rd_data_r | data1_r;
      AL_CLR:  alias_val = rd_data_r & ~data1_r;
      default: alias_val = rd_data_r ^ data1_r;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx0_r;
    wr_en   = 1'b0;
    wr_addr = idx0_r;
    wr_be   = 4'hF;
    wr_data = alias_val;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = clr_cnt_r[WORD_AW] ? '1 : '0;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_READ && rw_ok) begin
            rd_en   = 1'b1;
            rd_addr = file_index(in_domain, in_block_select, word0);
          end else if (in_op == OP_WRITE && rw_ok && is_alias) begin
            rd_en   = 1'b1;
            rd_addr = file_index(in_domain, in_block_select, alias_off[OFF_W-1:2]);
          end else if (in_op == OP_WRITE && rw_ok) begin
            wr_en   = 1'b1;
            wr_addr = file_index(in_domain, in_block_select, word0);
            wr_be   = be64[3:0];
            wr_data = wdata64[DATA_W-1:0];
          end else if (in_op == OP_QUERY && qry_ok) begin
            rd_en   = 1'b1;
            rd_addr = file_index(in_domain, 1'b0, word0);
          end
        end
      end
      S_RD0: begin
        rd_en   = span_r;
        rd_addr = idx1_r;
      end
      S_ALIAS: begin
        wr_en = 1'b1;
      end
      S_WR1: begin
        wr_en   = 1'b1;
        wr_addr = idx1_r;
        wr_be   = be1_r;
        wr_data = data1_r;
      end
      S_Q0: begin
        rd_en   = 1'b1;
        rd_addr = idx1_r;
      end
      S_Q1: begin
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE) || pending_r;

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      pending_r   <= 1'b0;
    end else begin
      // A finished result moves to the output register once that is free.
      if (pending_r && out_free) begin
        out_valid_r     <= 1'b1;
        out_read_data_r <= res_rd_r;
        out_ok_r        <= res_ok_r;
        out_act_r       <= res_act_r;
        pending_r       <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == MEM_AW'(TOTAL_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_rd_r  <= '0;
            res_ok_r  <= (in_op == OP_WRITE) && rw_ok && !is_alias;
            res_act_r <= 1'b0;
            span_r    <= span;
            lo_r      <= lo;
            size_r    <= in_access_size;
            be1_r     <= be64[7:4];
            alias_r   <= alias_kind;
            bit_r     <= in_bit_index;
            if (in_op == OP_READ && rw_ok) begin
              idx1_r  <= file_index(in_domain, in_block_select, word1);
              state_r <= S_RD0;
            end else if (in_op == OP_WRITE && rw_ok && is_alias) begin
              idx0_r  <= file_index(in_domain, in_block_select, alias_off[OFF_W-1:2]);
              data1_r <= in_write_data;
              state_r <= S_ALIAS;
            end else if (in_op == OP_WRITE && rw_ok) begin
              idx1_r  <= file_index(in_domain, in_block_select, word1);
              data1_r <= wdata64[2*DATA_W-1:DATA_W];
              if (span) begin
                state_r <= S_WR1;
              end else begin
                pending_r <= 1'b1;
              end
            end else if (in_op == OP_QUERY && qry_ok) begin
              idx1_r  <= file_index(in_domain, 1'b1, word0);
              state_r <= S_Q0;
            end else begin
              pending_r <= 1'b1;
            end
          end
        end
        S_RD0: begin
          w0_r <= rd_data_r;
          if (span_r) begin
            state_r <= S_RD1;
          end else begin
            res_rd_r  <= read_val;
            res_ok_r  <= 1'b1;
            pending_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        S_RD1: begin
          res_rd_r  <= read_val;
          res_ok_r  <= 1'b1;
          pending_r <= 1'b1;
          state_r   <= S_IDLE;
        end
        S_ALIAS: begin
          res_ok_r  <= 1'b1;
          pending_r <= 1'b1;
          state_r   <= S_IDLE;
        end
        S_WR1: begin
          pending_r <= 1'b1;
          state_r   <= S_IDLE;
        end
        S_Q0: begin
          w0_r    <= rd_data_r;
          state_r <= S_Q1;
        end
        S_Q1: begin
          res_ok_r  <= 1'b1;
          res_act_r <= w0_r[bit_r] & ~rd_data_r[bit_r];
          pending_r <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_data         = out_read_data_r;
  assign out_ok                = out_ok_r;
  assign out_peripheral_active = out_act_r;

  // The memory is written in the idle state only by a write beat being accepted.
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_IDLE) |-> accept)
    else $error("memory write in idle state without an accepted beat");

  // No beat is taken while the clearing pass runs.
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");

  // A new result only appears out of a pending result.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pending_r))
    else $error("result presented without a finished item");

  // An active peripheral is only reported by an accepted query.
  a_active_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_act_r) |-> (out_ok_r && out_read_data_r == '0))
    else $error("peripheral active reported on a failed or data access");

endmodule

### bench/clock_reset_control_regfile_tb.sv
module clock_reset_control_regfile_tb;
  import crrf_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
  localparam logic            CLOCK_FILE = 1'b0;
  localparam logic            RESET_FILE = 1'b1;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int QUIET_ITEMS    = 150;
  localparam int LONG_HOLD      = 120;
  localparam int DRAIN_CYCLES   = 12;
  // The clearing pass after reset is the longest stretch without a beat.
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              blk;
    logic              dom;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] wdata;
    logic [BIT_W-1:0]  bit_sel;
  } access_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              ok;
    logic              active;
  } reply_t;

  class regfile_scoreboard;
    logic [DATA_W-1:0] ctrl_words [TOTAL_WORDS];
    reply_t            expected_replies [$];
    int                mismatches;

    function new();
      mismatches = 0;
      for (int f = 0; f < DOMAINS * 2; f++) begin
        for (int w = 0; w < WORDS_PER_FILE; w++) begin
          ctrl_words[f * WORDS_PER_FILE + w] = (f % 2 == 1) ? '1 : '0;
        end
      end
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction

    // Applies one accepted access to the register image and queues its reply.
    function void note_access(access_t a);
      reply_t want;
      int     base;
      int     idx;
      int     p;
      bit     alias_hit;
      want = '0;
      if (a.op == OP_QUERY) begin
        if (a.offset >= CTRL_FIRST && a.offset <= CTRL_LAST) begin
          idx = int'(a.offset) / 4;
          base = int'(a.dom) * 2 * WORDS_PER_FILE;
          want.ok = 1'b1;
          want.active = ctrl_words[base + idx][a.bit_sel] &&
                        !ctrl_words[base + WORDS_PER_FILE + idx][a.bit_sel];
        end
      end else if (a.op == OP_READ || a.op == OP_WRITE) begin
        if (a.size >= 1 && a.size <= 4 && int'(a.offset) + int'(a.size) <= BLOCK_BYTES) begin
          base = (int'(a.dom) * 2 + int'(a.blk)) * WORDS_PER_FILE;
          want.ok = 1'b1;
          alias_hit = 1'b0;
          // Only full-word writes hit the set/clear/toggle windows.
          if (a.op == OP_WRITE && a.size == 4) begin
            if (a.offset >= ALIAS_SET && a.offset <= ALIAS_SET + ALIAS_SPAN) begin
              idx = base + int'(a.offset - ALIAS_SET + CTRL_FIRST) / 4;
              ctrl_words[idx] |= a.wdata;
              alias_hit = 1'b1;
            end else if (a.offset >= ALIAS_CLR && a.offset <= ALIAS_CLR + ALIAS_SPAN) begin
              idx = base + int'(a.offset - ALIAS_CLR + CTRL_FIRST) / 4;
              ctrl_words[idx] &= ~a.wdata;
              alias_hit = 1'b1;
            end else if (a.offset >= ALIAS_TOG && a.offset <= ALIAS_TOG + ALIAS_SPAN) begin
              idx = base + int'(a.offset - ALIAS_TOG + CTRL_FIRST) / 4;
              ctrl_words[idx] ^= a.wdata;
              alias_hit = 1'b1;
            end
          end
          for (int i = 0; i < int'(a.size); i++) begin
            p = int'(a.offset) + i;
            if (a.op == OP_READ) begin
              want.rdata[8 * i +: 8] = ctrl_words[base + p / 4][8 * (p % 4) +: 8];
            end else if (!alias_hit) begin
              ctrl_words[base + p / 4][8 * (p % 4) +: 8] = a.wdata[8 * i +: 8];
            end
          end
        end
      end
      expected_replies.push_back(want);
    endfunction

    function void check_result(logic [DATA_W-1:0] rdata, logic ok, logic active);
      reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: rd=%h ok=%b act=%b", rdata, ok, active);
        end
        return;
      end
      want = expected_replies.pop_front();
      if (rdata !== want.rdata || ok !== want.ok || active !== want.active) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected rd=%h ok=%b act=%b, got rd=%h ok=%b act=%b",
                   want.rdata, want.ok, want.active, rdata, ok, active);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_op;
  logic              in_block_select;
  logic              in_domain;
  logic [OFF_W-1:0]  in_byte_offset;
  logic [SIZE_W-1:0] in_access_size;
  logic [DATA_W-1:0] in_write_data;
  logic [BIT_W-1:0]  in_bit_index;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] out_read_data;
  logic              out_ok;
  logic              out_peripheral_active;

  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;

  regfile_scoreboard board = new();

  clock_reset_control_regfile dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_op                 (in_op),
    .in_block_select       (in_block_select),
    .in_domain             (in_domain),
    .in_byte_offset        (in_byte_offset),
    .in_access_size        (in_access_size),
    .in_write_data         (in_write_data),
    .in_bit_index          (in_bit_index),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_read_data         (out_read_data),
    .out_ok                (out_ok),
    .out_peripheral_active (out_peripheral_active)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offers one access, with an occasional idle burst ahead of it, and waits for its beat.
  task automatic issue_access(input logic [OP_W-1:0] op, input logic blk, input logic dom,
                              input logic [OFF_W-1:0] off, input logic [SIZE_W-1:0] size,
                              input logic [DATA_W-1:0] data, input logic [BIT_W-1:0] bit_sel);
    access_t acc;
    acc = '{op, blk, dom, off, size, data, bit_sel};
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_block_select <= blk;
    in_domain       <= dom;
    in_byte_offset  <= off;
    in_access_size  <= size;
    in_write_data   <= data;
    in_bit_index    <= bit_sel;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_access(acc);
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        board.check_result(out_read_data, out_ok, out_peripheral_active);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 12) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("** clock_reset_control_regfile: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int                sel;
    int                pick;
    logic [OP_W-1:0]   op;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] data;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_op           <= OP_READ;
    in_block_select <= CLOCK_FILE;
    in_domain       <= 1'b0;
    in_byte_offset  <= '0;
    in_access_size  <= '0;
    in_write_data   <= '0;
    in_bit_index    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset contents, then plain and word-spanning accesses.
    issue_access(OP_READ,  CLOCK_FILE, 1'b0, 12'h010, 3'd4, 32'h0, 5'd0);
    issue_access(OP_READ,  RESET_FILE, 1'b0, 12'h010, 3'd4, 32'h0, 5'd0);
    issue_access(OP_WRITE, CLOCK_FILE, 1'b0, 12'h010, 3'd4, 32'h12345678, 5'd0);
    issue_access(OP_READ,  CLOCK_FILE, 1'b0, 12'h013, 3'd4, 32'h0, 5'd0);
    issue_access(OP_WRITE, CLOCK_FILE, 1'b0, 12'h016, 3'd3, 32'h00AABBCC, 5'd0);
    issue_access(OP_READ,  CLOCK_FILE, 1'b0, 12'h014, 3'd4, 32'h0, 5'd0);
    // Bad sizes and the end of the file.
    issue_access(OP_READ,  CLOCK_FILE, 1'b0, 12'h010, 3'd0, 32'h0, 5'd0);
    issue_access(OP_WRITE, CLOCK_FILE, 1'b0, 12'h010, 3'd5, 32'hFFFFFFFF, 5'd0);
    issue_access(OP_READ,  RESET_FILE, 1'b1, 12'h020, 3'd7, 32'h0, 5'd0);
    issue_access(OP_READ,  RESET_FILE, 1'b1, 12'hFFC, 3'd4, 32'h0, 5'd0);
    issue_access(OP_WRITE, CLOCK_FILE, 1'b1, 12'hFFD, 3'd4, 32'hFFFFFFFF, 5'd0);
    issue_access(OP_READ,  RESET_FILE, 1'b1, 12'hFFF, 3'd1, 32'h0, 5'd0);
    issue_access(OP_READ,  RESET_FILE, 1'b1, 12'hFFF, 3'd2, 32'h0, 5'd0);
    // Set the clock bit and clear the reset bit, then ask whether it runs.
    issue_access(OP_WRITE, CLOCK_FILE, 1'b0, 12'h044, 3'd4, 32'h80000001, 5'd0);
    issue_access(OP_WRITE, RESET_FILE, 1'b0, 12'h074, 3'd4, 32'h00000001, 5'd0);
    issue_access(OP_QUERY, RESET_FILE, 1'b0, 12'h014, 3'd0, 32'h0, 5'd0);
    issue_access(OP_QUERY, CLOCK_FILE, 1'b0, 12'h014, 3'd4, 32'h0, 5'd31);
    // Unaligned toggle lands on the same word; unaligned query offset too.
    issue_access(OP_WRITE, RESET_FILE, 1'b0, 12'h0A5, 3'd4, 32'h80000000, 5'd0);
    issue_access(OP_QUERY, CLOCK_FILE, 1'b0, 12'h017, 3'd1, 32'h0, 5'd31);
    // A short write into an alias window is stored as plain bytes.
    issue_access(OP_WRITE, CLOCK_FILE, 1'b1, 12'h048, 3'd2, 32'hFFFFFFFF, 5'd0);
    issue_access(OP_READ,  CLOCK_FILE, 1'b1, 12'h048, 3'd4, 32'h0, 5'd0);
    issue_access(OP_QUERY, CLOCK_FILE, 1'b0, 12'h00F, 3'd4, 32'h0, 5'd0);
    issue_access(OP_QUERY, CLOCK_FILE, 1'b1, 12'h019, 3'd4, 32'h0, 5'd0);
    issue_access(OP_QUERY, RESET_FILE, 1'b1, 12'h018, 3'd7, 32'h0, 5'd5);
    issue_access(OP_UNUSED, RESET_FILE, 1'b1, 12'h010, 3'd4, 32'hFFFFFFFF, 5'd31);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      if (n == RANDOM_ITEMS / 4) begin
        long_hold_req = 1'b1;
      end
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (board.outstanding() != 0);
      end
      sel = $urandom_range(0, 99);
      op = (sel < 38) ? OP_READ : (sel < 76) ? OP_WRITE : (sel < 96) ? OP_QUERY : OP_UNUSED;
      pick = $urandom_range(0, 99);
      if (op == OP_QUERY && pick < 75) begin
        off = OFF_W'($urandom_range(CTRL_FIRST, CTRL_LAST));
      end else if (pick < 55) begin
        off = OFF_W'($urandom_range(CTRL_FIRST - 4, ALIAS_TOG + ALIAS_SPAN + 4));
      end else if (pick < 72) begin
        off = OFF_W'($urandom_range(BLOCK_BYTES - 8, BLOCK_BYTES - 1));
      end else begin
        off = OFF_W'($urandom_range(0, BLOCK_BYTES - 1));
      end
      pick = $urandom_range(0, 99);
      size = (pick < 12) ? SIZE_W'($urandom_range(0, 7)) :
             (pick < 60) ? 3'd4 : SIZE_W'($urandom_range(1, 3));
      // Single-bit masks make set, clear and toggle effects easy to spot in queries.
      data = ($urandom_range(0, 99) < 20) ? (32'h1 << $urandom_range(0, 31)) : $urandom;
      issue_access(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), off, size, data,
                   BIT_W'($urandom_range(0, 31)));
    end

    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("** clock_reset_control_regfile: PASSED **");
    end else begin
      $display("** clock_reset_control_regfile: FAILED **");
    end
    $finish;
  end

endmodule
